// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the min tracking stack.
// Depends on a clock named clock and a synchronous reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define MTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define MTS_ASSERT_IMP(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence in the next cycle
`define MTS_ASSERT_NXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/mts_pkg.sv -----
// Package of the min tracking stack: word width, operation and status codes,
// and the shift control passed down the cell chains. No dependencies.
`default_nettype none

package mts_pkg;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 8;

   // Operation codes of a request beat
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } mts_status_type;

   typedef logic signed [WORD_W-1:0] mts_word_type;

   // Shift control for one chain: push moves every word one cell down,
   // pop moves every word one cell up
   typedef struct packed {
      logic push;
      logic pop;
   } mts_shift_type;

endpackage

`default_nettype wire

// ----- src/mts_if.sv -----
// Valid/ready channel interfaces of the min tracking stack: request and response.
// Depends on mts_pkg for the word and occupancy widths.
`default_nettype none

interface mts_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [mts_pkg::WORD_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic signed [mts_pkg::WORD_W-1:0] popped_value;
   logic signed [mts_pkg::WORD_W-1:0] min_value;
   logic                         min_valid;
   logic [mts_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output popped_value, output min_value,
                   output min_valid, output occupancy, input ready);
   modport sink   (input valid, input status, input popped_value, input min_value,
                   input min_valid, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/mts_cell.sv -----
// One storage cell of a stack chain: holds a word and takes its neighbor's.
// Depends on mts_pkg.
`default_nettype none

module mts_cell (
   input  wire logic                 clock,
   input  wire mts_pkg::mts_shift_type shift,
   input  wire mts_pkg::mts_word_type  above_word,
   input  wire mts_pkg::mts_word_type  below_word,
   output      mts_pkg::mts_word_type  word
);
   import mts_pkg::*;

   mts_word_type word_ff;
   mts_word_type word_in;

   // Take the upper word on push, the lower word on pop, else hold
   always_comb begin
      word_in = word_ff;
      if (shift.push) begin
         word_in = above_word;
      end else if (shift.pop) begin
         word_in = below_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// ----- src/mts_chain.sv -----
// A stack built as a row of shifting cells; cell zero is the top of stack.
// Depends on mts_pkg and mts_cell.
`default_nettype none

module mts_chain #(
   parameter int DEPTH = 128
) (
   input  wire logic                  clock,
   input  wire mts_pkg::mts_shift_type shift,
   input  wire mts_pkg::mts_word_type  push_word,
   output      mts_pkg::mts_word_type  top_word,
   output      mts_pkg::mts_word_type  next_word
);
   import mts_pkg::*;

   mts_word_type cell_word [DEPTH];

   // Link each cell to its neighbors; the top takes the pushed word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mts_word_type above;
      mts_word_type below;

      if (i == 0) begin : g_top
         assign above = push_word;
      end else begin : g_mid
         assign above = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_bot
         assign below = '0;
      end else begin : g_upper
         assign below = cell_word[i+1];
      end

      mts_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .above_word (above),
         .below_word (below),
         .word       (cell_word[i])
      );
   end

   assign top_word  = cell_word[0];
   assign next_word = cell_word[1];

endmodule

`default_nettype wire

// ----- src/min_tracking_stack.sv -----
// Top level of the min tracking stack: counts, control, response register.
// Depends on mts_pkg, mts_if, mts_chain and assert_macros.svh.
//
//   channel  dir  fields                                           beat
//   req_if   in   mode, value                                      push or pop
//   rsp_if   out  status, popped_value, min_value, min_valid,      one per request
//                 occupancy
//
// One request beat per cycle when not stalled; its response appears in the next cycle.
// The rate is set by the top-cell compare and the shift of every cell in both chains.
// Reset clears both counts and the response valid; cell contents are not reset.
// A response held by a low rsp_if.ready stalls the request side until it is taken.
`default_nettype none

module min_tracking_stack #(
   parameter int DEPTH = 128
) (
   input wire logic clock,
   input wire logic reset,
   mts_req_if.sink  req_if,
   mts_rsp_if.source rsp_if
);
   import mts_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] main_count_ff, main_count_in;
   logic [CW-1:0] min_count_ff, min_count_in;

   logic           rsp_valid_ff, rsp_valid_in;
   mts_status_type rsp_status_ff, rsp_status_in;
   mts_word_type   rsp_popped_ff, rsp_popped_in;
   mts_word_type   rsp_min_ff, rsp_min_in;
   logic           rsp_min_valid_ff, rsp_min_valid_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic           accept;
   logic           is_push;
   logic           main_full, main_empty, min_full, min_empty;
   logic           push_rejected, pop_rejected, pop_deep;
   mts_shift_type  main_shift, min_shift;
   mts_word_type   main_top, main_next, min_top, min_next;
   mts_word_type   min_new_top;
   logic [CW+OCC_W-1:0] occ_ext;

   // Take a request whenever the response register is free or being emptied
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_push      = (req_if.mode == MODE_PUSH);

   assign main_full  = (main_count_ff == CW'(DEPTH));
   assign main_empty = (main_count_ff == '0);
   assign min_full   = (min_count_ff == CW'(DEPTH));
   assign min_empty  = (min_count_ff == '0);

   // Flag rejected beats and pops that expose a second stored word
   assign push_rejected = accept && is_push && main_full;
   assign pop_rejected  = accept && !is_push && main_empty;
   assign pop_deep      = main_shift.pop && (main_count_ff > CW'(1));

   // Decide the shifts of both chains from the top cells
   always_comb begin
      main_shift.push = accept && is_push && !main_full;
      main_shift.pop  = accept && !is_push && !main_empty;
      min_shift.push  = main_shift.push &&
                        (min_empty || (!min_full && (req_if.value <= min_top)));
      min_shift.pop   = main_shift.pop && !min_empty && (min_top == main_top);
   end

   // Advance the counts and build the response
   always_comb begin
      main_count_in = main_count_ff;
      min_count_in  = min_count_ff;
      min_new_top   = min_top;
      rsp_status_in = ST_OK;
      rsp_popped_in = '0;

      if (main_shift.push) begin
         main_count_in = main_count_ff + CW'(1);
      end else if (main_shift.pop) begin
         main_count_in = main_count_ff - CW'(1);
         rsp_popped_in = main_top;
      end

      if (min_shift.push) begin
         min_count_in = min_count_ff + CW'(1);
         min_new_top  = req_if.value;
      end else if (min_shift.pop) begin
         min_count_in = min_count_ff - CW'(1);
         min_new_top  = min_next;
      end

      if (push_rejected) begin
         rsp_status_in = ST_OVERFLOW;
      end else if (pop_rejected) begin
         rsp_status_in = ST_UNDERFLOW;
      end

      rsp_min_valid_in = (main_count_in != '0) && (min_count_in != '0);
      rsp_min_in       = rsp_min_valid_in ? min_new_top : '0;
      occ_ext          = {{OCC_W{1'b0}}, main_count_in};
      rsp_occ_in       = occ_ext[OCC_W-1:0];

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_count_ff <= '0;
         min_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         main_count_ff <= main_count_in;
         min_count_ff  <= min_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load the response payload on each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_popped_ff    <= rsp_popped_in;
         rsp_min_ff       <= rsp_min_in;
         rsp_min_valid_ff <= rsp_min_valid_in;
         rsp_occ_ff       <= rsp_occ_in;
      end
   end

   // Main stack and min stack cell chains
   mts_chain #(.DEPTH(DEPTH)) u_main_chain (
      .clock     (clock),
      .shift     (main_shift),
      .push_word (req_if.value),
      .top_word  (main_top),
      .next_word (main_next)
   );

   mts_chain #(.DEPTH(DEPTH)) u_min_chain (
      .clock     (clock),
      .shift     (min_shift),
      .push_word (req_if.value),
      .top_word  (min_top),
      .next_word (min_next)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.popped_value = rsp_popped_ff;
   assign rsp_if.min_value    = rsp_min_ff;
   assign rsp_if.min_valid    = rsp_min_valid_ff;
   assign rsp_if.occupancy    = rsp_occ_ff;

`include "assert_macros.svh"

   `MTS_ASSERT(a_min_le_main, min_count_ff <= main_count_ff, "min stack deeper than main stack")
   `MTS_ASSERT_IMP(a_min_nonempty, !main_empty, !min_empty, "min stack empty with entries")
   `MTS_ASSERT_IMP(a_rsp_min_valid, rsp_valid_ff, rsp_min_valid_ff == !main_empty, "bad min_valid")
   `MTS_ASSERT_NXT(a_underflow_hold, pop_rejected, main_empty && min_empty, "bad underflow")
   `MTS_ASSERT_NXT(a_pop_shift, pop_deep, main_top == $past(main_next), "pop lost next word")

endmodule

`default_nettype wire

// ----- tb/min_tracking_stack_tb.sv -----
`timescale 1ns / 100ps
// Testbench of the min tracking stack: directed and random push/pop beats with an
// in-place predictor and a beat-by-beat response check. Depends on mts_pkg, mts_if, RTL.
module min_tracking_stack_tb;
   import mts_pkg::*;

   localparam int STACK_DEPTH  = 128;
   localparam int MAX_GAP      = 13;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BEATS = 660;
   localparam int MAX_PRINTS   = 40;
   localparam mts_word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam mts_word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   typedef struct {
      mts_status_type     status;
      mts_word_type       popped_value;
      mts_word_type       min_value;
      logic               min_valid;
      logic [OCC_W-1:0]   occupancy;
   } stack_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mts_req_if req_bus ();
   mts_rsp_if rsp_bus ();

   min_tracking_stack #(.DEPTH(STACK_DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Predicted contents of both stacks
   mts_word_type stack_words [STACK_DEPTH];
   mts_word_type min_words [STACK_DEPTH];
   int unsigned  stack_count = 0;
   int unsigned  min_count = 0;

   stack_reply_type pending_replies [$];
   int unsigned  error_count = 0;
   bit           no_idle = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // Apply one accepted beat to the predicted stacks and build its reply
   function automatic stack_reply_type predict_stack_op(input logic mode,
                                                        input mts_word_type value);
      stack_reply_type r;
      r.status = ST_OK;
      r.popped_value = '0;
      if (mode == MODE_PUSH) begin
         if (stack_count >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
         end else begin
            stack_words[stack_count] = value;
            stack_count++;
            // track a new minimum, duplicates of the minimum included
            if (min_count == 0) begin
               min_words[0] = value;
               min_count = 1;
            end else if (min_count < STACK_DEPTH && value <= min_words[min_count-1]) begin
               min_words[min_count] = value;
               min_count++;
            end
         end
      end else begin
         if (stack_count == 0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            stack_count--;
            r.popped_value = stack_words[stack_count];
            if (min_count > 0 && min_words[min_count-1] == r.popped_value) min_count--;
         end
      end
      if (stack_count > 0 && min_count > 0) begin
         r.min_value = min_words[min_count-1];
         r.min_valid = 1'b1;
      end else begin
         r.min_value = '0;
         r.min_valid = 1'b0;
      end
      r.occupancy = OCC_W'(stack_count);
      return r;
   endfunction

   // Mix of extremes, a narrow band around zero for repeated minima, and full range
   function automatic mts_word_type draw_value();
      case ($urandom_range(0, 9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2, 3, 4, 5: return mts_word_type'($urandom_range(0, 16)) - 8;
         default: return mts_word_type'($urandom());
      endcase
   endfunction

   // Send one request beat; valid stays high when the next beat follows at once
   task automatic send_op(input logic mode, input mts_word_type value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_replies.push_back(predict_stack_op(mode, value));
   endtask

   // Hold off the request side until every reply has come back
   task automatic drain_replies();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // Pops on an empty stack, then single entries at both extremes
   task automatic test_empty_stack();
      send_op(MODE_POP, '0);
      send_op(MODE_POP, '1);
      send_op(MODE_PUSH, WORD_MIN);
      send_op(MODE_POP, WORD_MAX);
      send_op(MODE_PUSH, WORD_MAX);
      send_op(MODE_POP, WORD_MIN);
   endtask

   // Minimum tracking: values above the minimum, equal duplicates, new minima
   task automatic test_min_tracking();
      send_op(MODE_PUSH, 5);
      send_op(MODE_PUSH, 7);
      send_op(MODE_PUSH, 5);
      send_op(MODE_PUSH, -3);
      send_op(MODE_PUSH, WORD_MAX);
      send_op(MODE_PUSH, WORD_MIN);
      send_op(MODE_PUSH, WORD_MIN);
      repeat (8) send_op(MODE_POP, mts_word_type'($urandom()));
   endtask

   // Fill to full twice: descending values fill the min stack too, then random
   // values back to back; push past full, then pop past empty
   task automatic test_fill_and_overflow();
      mts_word_type next_value;
      for (int pass = 0; pass < 2; pass++) begin
         no_idle = (pass == 1);
         next_value = WORD_MIN + STACK_DEPTH - 1;
         while (stack_count < STACK_DEPTH) begin
            send_op(MODE_PUSH, pass == 0 ? next_value : draw_value());
            next_value = next_value - 1;
         end
         if (pass == 0) drain_replies();
         send_op(MODE_PUSH, WORD_MIN);
         send_op(MODE_PUSH, draw_value());
         while (stack_count > 0) send_op(MODE_POP, mts_word_type'($urandom()));
         send_op(MODE_POP, mts_word_type'($urandom()));
      end
      no_idle = 1'b0;
   endtask

   // Random segments, each with its own push bias and idling on or off
   task automatic test_random_mix(input int unsigned count);
      int unsigned sent;
      int          push_pct;
      int          seg_len;
      sent = 0;
      while (sent < count) begin
         seg_len = $urandom_range(20, 120);
         case ($urandom_range(0, 4))
            0: push_pct = 25;
            1: push_pct = 50;
            2: push_pct = 60;
            3: push_pct = 80;
            default: push_pct = 97;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            if ($urandom_range(1, 100) <= push_pct) send_op(MODE_PUSH, draw_value());
            else send_op(MODE_POP, mts_word_type'($urandom()));
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin : run_tests
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_PUSH;
      req_bus.value = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_min_tracking();
      test_fill_and_overflow();
      test_random_mix(RANDOM_BEATS);
      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Take reply beats with random stalls and compare against the oldest prediction
   initial begin : reply_check
      int              stall;
      stack_reply_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && reset === 1'b0));
         if (pending_replies.size() == 0) begin
            report_mismatch("reply beat with no request outstanding");
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", rsp_bus.status,
                                         want.status));
            if (rsp_bus.popped_value !== want.popped_value)
               report_mismatch($sformatf("popped_value got %0d want %0d",
                                         rsp_bus.popped_value, want.popped_value));
            if (rsp_bus.min_value !== want.min_value)
               report_mismatch($sformatf("min_value got %0d want %0d", rsp_bus.min_value,
                                         want.min_value));
            if (rsp_bus.min_valid !== want.min_valid)
               report_mismatch($sformatf("min_valid got %b want %b", rsp_bus.min_valid,
                                         want.min_valid));
            if (rsp_bus.occupancy !== want.occupancy)
               report_mismatch($sformatf("occupancy got %0d want %0d", rsp_bus.occupancy,
                                         want.occupancy));
         end
      end
   end

   // Stop a hung run
   initial begin : watchdog
      #(6_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/mts_pkg.sv
src/mts_if.sv
src/mts_cell.sv
src/mts_chain.sv
src/min_tracking_stack.sv
tb/min_tracking_stack_tb.sv
